>>> rtl/core/cblt_pkg.sv
package cblt_pkg;

  localparam int VAL_W     = 16;
  localparam int CMD_W     = 2;
  localparam int IDX_W     = 4;
  localparam int CFG_W     = 5;
  localparam int CFG_IDX_W = 2;
  localparam int W_W       = 16;
  localparam int DEN_W     = 32;
  localparam int MUL_W     = 33;
  localparam int ACC_W     = 50;
  localparam int QUO_W     = 17;
  localparam int LO_W      = 8;

  localparam int DEF_MAX_X_POINTS = 16;
  localparam int DEF_MAX_Y_POINTS = 16;

  localparam logic [CMD_W-1:0] CMD_QUERY = 2'd0;
  localparam logic [CMD_W-1:0] CMD_WR_X  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_WR_Y  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_WR_G  = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_X_POINTS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_Y_POINTS = 2'd1;

  typedef struct packed {
    logic                    done;
    logic                    bracket;
    logic [LO_W-1:0]         lo;
    logic signed [VAL_W-1:0] lo_val;
    logic signed [VAL_W-1:0] hi_val;
  } srch_res_t;

endpackage

>>> rtl/core/cblt_if.sv
interface cblt_in_if import cblt_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [CMD_W-1:0]        command;
  logic [IDX_W-1:0]        row_index;
  logic [IDX_W-1:0]        col_index;
  logic signed [VAL_W-1:0] write_value;
  logic signed [VAL_W-1:0] query_x;
  logic signed [VAL_W-1:0] query_y;

  modport source (output valid, command, row_index, col_index, write_value, query_x,
                  query_y, input ready);
  modport sink (input valid, command, row_index, col_index, write_value, query_x,
                query_y, output ready);
endinterface

interface cblt_out_if import cblt_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [VAL_W-1:0] result_value;
  logic [1:0]              clamp_flags;

  modport source (output valid, result_value, clamp_flags, input ready);
  modport sink (input valid, result_value, clamp_flags, output ready);
endinterface

>>> rtl/core/cblt_search.sv
module cblt_search import cblt_pkg::*; #(
  parameter int DEPTH = DEF_MAX_X_POINTS,
  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    wr_en_i,
  input  logic [IW-1:0]           wr_addr_i,
  input  logic signed [VAL_W-1:0] wr_data_i,
  input  logic                    start_i,
  input  logic [IW-1:0]           last_i,
  input  logic signed [VAL_W-1:0] coord_i,
  output srch_res_t               res_o
);

  logic signed [VAL_W-1:0] mem_q [DEPTH];
  logic signed [VAL_W-1:0] rd_q;
  logic signed [VAL_W-1:0] prev_q;
  logic signed [VAL_W-1:0] coord_q;
  logic [IW-1:0]           rd_addr;
  logic [IW-1:0]           cnt_q;
  logic [IW-1:0]           last_q;
  logic                    busy_q;
  logic                    done_q;
  logic                    bracket_q;
  logic [LO_W-1:0]         lo_q;
  logic signed [VAL_W-1:0] lo_val_q;
  logic signed [VAL_W-1:0] hi_val_q;
  logic                    fin;
  logic                    fin_br;
  logic [LO_W-1:0]         fin_lo;

  assign rd_addr = start_i ? '0 : cnt_q + 1'b1;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    rd_q <= mem_q[rd_addr];
  end

  always_comb begin
    fin    = 1'b0;
    fin_br = 1'b0;
    fin_lo = LO_W'(last_q);
    if (cnt_q == '0) begin
      if (coord_q <= rd_q) begin
        fin    = 1'b1;
        fin_lo = '0;
      end else if (cnt_q == last_q) begin
        fin = 1'b1;
      end
    end else begin
      if (coord_q < rd_q) begin
        fin    = 1'b1;
        fin_br = 1'b1;
        fin_lo = LO_W'(cnt_q - 1'b1);
      end else if (cnt_q == last_q) begin
        fin = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
    end else if (busy_q && fin) begin
      busy_q <= 1'b0;
      done_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      cnt_q   <= '0;
      last_q  <= last_i;
      coord_q <= coord_i;
    end else if (busy_q) begin
      prev_q <= rd_q;
      if (fin) begin
        bracket_q <= fin_br;
        lo_q      <= fin_lo;
        lo_val_q  <= prev_q;
        hi_val_q  <= rd_q;
      end else begin
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  assign res_o = '{done: done_q, bracket: bracket_q, lo: lo_q, lo_val: lo_val_q,
                   hi_val: hi_val_q};

endmodule

>>> rtl/core/cblt_mul.sv
module cblt_mul import cblt_pkg::*; (
  input  logic                    clk_i,
  input  logic signed [MUL_W-1:0] a_i,
  input  logic signed [MUL_W-1:0] b_i,
  output logic signed [ACC_W-1:0] p_o
);

  logic signed [2*MUL_W-1:0] prod;
  logic signed [ACC_W-1:0]   p_q;

  assign prod = a_i * b_i;

  always_ff @(posedge clk_i) begin
    p_q <= ACC_W'(prod);
  end

  assign p_o = p_q;

endmodule

>>> rtl/core/cblt_div.sv
module cblt_div import cblt_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [ACC_W-1:0]   num_i,
  input  logic [DEN_W:0]     den_i,
  output logic               done_o,
  output logic [QUO_W-1:0]   quo_o
);

  logic [ACC_W-1:0] rem_q;
  logic [ACC_W-1:0] dv_q;
  logic [QUO_W-1:0] quo_q;
  logic [4:0]       step_q;
  logic             busy_q;
  logic             done_q;
  logic             ge;

  assign ge = (rem_q >= dv_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
      end else if (busy_q && step_q == '0) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= num_i;
      dv_q   <= ACC_W'(den_i) << (QUO_W - 1);
      quo_q  <= '0;
      step_q <= 5'(QUO_W - 1);
    end else if (busy_q) begin
      if (ge) begin
        rem_q <= rem_q - dv_q;
      end
      quo_q  <= {quo_q[QUO_W-2:0], ge};
      dv_q   <= dv_q >> 1;
      step_q <= step_q - 1'b1;
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

>>> rtl/core/clamped_bilinear_table_lookup_top.sv
// Bilinear lookup in a loaded calibration map. Items write x axis points, y axis points or grid
// values, or query (x, y); each item gives one result. A query searches the two axes in parallel,
// one point per cycle from registered axis memories; then one shared multiplier forms the cell
// area and the four corner terms, and a restoring divider rounds the sum. The block takes no item
// until the current one has moved into the output register.
module clamped_bilinear_table_lookup_top import cblt_pkg::*; #(
  parameter int MAX_X_POINTS = DEF_MAX_X_POINTS,
  parameter int MAX_Y_POINTS = DEF_MAX_Y_POINTS
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  cblt_in_if.sink              in_i,
  cblt_out_if.source           out_o
);

  localparam int XW   = (MAX_X_POINTS > 1) ? $clog2(MAX_X_POINTS) : 1;
  localparam int YW   = (MAX_Y_POINTS > 1) ? $clog2(MAX_Y_POINTS) : 1;
  localparam int GD   = MAX_X_POINTS * MAX_Y_POINTS;
  localparam int GA_W = (GD > 1) ? $clog2(GD) : 1;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_SRCH = 4'd1;
  localparam logic [3:0] S_DEN  = 4'd2;
  localparam logic [3:0] S_DENW = 4'd3;
  localparam logic [3:0] S_MUL1 = 4'd4;
  localparam logic [3:0] S_MUL2 = 4'd5;
  localparam logic [3:0] S_ACC  = 4'd6;
  localparam logic [3:0] S_DIVS = 4'd7;
  localparam logic [3:0] S_DIV  = 4'd8;
  localparam logic [3:0] S_FIN  = 4'd9;

  logic [3:0]              state_q;
  logic [CFG_W-1:0]        x_points_q;
  logic [CFG_W-1:0]        y_points_q;
  logic [XW-1:0]           x_last;
  logic [YW-1:0]           y_last;
  logic                    acc;
  logic                    x_we;
  logic                    y_we;
  logic                    g_we;
  logic                    q_start;
  srch_res_t               x_res;
  srch_res_t               y_res;
  logic signed [VAL_W-1:0] qx_q;
  logic signed [VAL_W-1:0] qy_q;
  logic signed [VAL_W:0]   x2mq, qmx1, x2mx1, y2mq, qmy1, y2my1;
  logic [W_W-1:0]          wxa_q, wxb_q, wya_q, wyb_q, dxw_q, dyw_q;
  logic [XW-1:0]           xi_q;
  logic [YW-1:0]           yi_q;
  logic [1:0]              flags_q;
  logic [1:0]              k_q;
  logic [DEN_W-1:0]        den_q;
  logic signed [ACC_W-1:0] acc_q;
  logic [ACC_W-1:0]        acc_abs;
  logic                    neg_q;
  logic signed [MUL_W-1:0] mul_a;
  logic signed [MUL_W-1:0] mul_b;
  logic signed [ACC_W-1:0] mul_p;
  logic                    div_start;
  logic                    div_done;
  logic [QUO_W-1:0]        div_quo;
  logic signed [VAL_W-1:0] res_q;
  logic signed [VAL_W-1:0] grid_q [GD];
  logic signed [VAL_W-1:0] grid_rd_q;
  logic [GA_W-1:0]         g_waddr;
  logic [GA_W-1:0]         g_raddr;
  logic                    out_valid_q;
  logic signed [VAL_W-1:0] out_value_q;
  logic [1:0]              out_flags_q;
  logic                    out_load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_points_q <= CFG_W'(1);
      y_points_q <= CFG_W'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_X_POINTS: x_points_q <= cfg_data_i;
        CFG_Y_POINTS: y_points_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (x_points_q == '0) begin
      x_last = '0;
    end else if (32'(x_points_q) > MAX_X_POINTS) begin
      x_last = XW'(MAX_X_POINTS - 1);
    end else begin
      x_last = XW'(x_points_q - 1'b1);
    end
    if (y_points_q == '0) begin
      y_last = '0;
    end else if (32'(y_points_q) > MAX_Y_POINTS) begin
      y_last = YW'(MAX_Y_POINTS - 1);
    end else begin
      y_last = YW'(y_points_q - 1'b1);
    end
  end

  assign in_i.ready = (state_q == S_IDLE);
  assign acc        = in_i.valid && in_i.ready;
  assign q_start    = acc && (in_i.command == CMD_QUERY);
  assign x_we       = acc && (in_i.command == CMD_WR_X) && (32'(in_i.row_index) < MAX_X_POINTS);
  assign y_we       = acc && (in_i.command == CMD_WR_Y) && (32'(in_i.col_index) < MAX_Y_POINTS);
  assign g_we       = acc && (in_i.command == CMD_WR_G) && (32'(in_i.row_index) < MAX_X_POINTS)
                      && (32'(in_i.col_index) < MAX_Y_POINTS);

  cblt_search #(.DEPTH(MAX_X_POINTS)) u_x_search (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (x_we),
    .wr_addr_i (XW'(in_i.row_index)),
    .wr_data_i (in_i.write_value),
    .start_i   (q_start),
    .last_i    (x_last),
    .coord_i   (in_i.query_x),
    .res_o     (x_res)
  );

  cblt_search #(.DEPTH(MAX_Y_POINTS)) u_y_search (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (y_we),
    .wr_addr_i (YW'(in_i.col_index)),
    .wr_data_i (in_i.write_value),
    .start_i   (q_start),
    .last_i    (y_last),
    .coord_i   (in_i.query_y),
    .res_o     (y_res)
  );

  assign g_waddr = GA_W'(32'(in_i.row_index) * MAX_Y_POINTS + 32'(in_i.col_index));
  assign g_raddr = GA_W'((32'(xi_q) + 32'(k_q[1])) * MAX_Y_POINTS + 32'(yi_q) + 32'(k_q[0]));

  always_ff @(posedge clk_i) begin
    if (g_we) begin
      grid_q[g_waddr] <= in_i.write_value;
    end
    grid_rd_q <= grid_q[g_raddr];
  end

  assign x2mq  = {x_res.hi_val[VAL_W-1], x_res.hi_val} - {qx_q[VAL_W-1], qx_q};
  assign qmx1  = {qx_q[VAL_W-1], qx_q} - {x_res.lo_val[VAL_W-1], x_res.lo_val};
  assign x2mx1 = {x_res.hi_val[VAL_W-1], x_res.hi_val}
                 - {x_res.lo_val[VAL_W-1], x_res.lo_val};
  assign y2mq  = {y_res.hi_val[VAL_W-1], y_res.hi_val} - {qy_q[VAL_W-1], qy_q};
  assign qmy1  = {qy_q[VAL_W-1], qy_q} - {y_res.lo_val[VAL_W-1], y_res.lo_val};
  assign y2my1 = {y_res.hi_val[VAL_W-1], y_res.hi_val}
                 - {y_res.lo_val[VAL_W-1], y_res.lo_val};

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      S_DEN: begin
        mul_a = MUL_W'(dxw_q);
        mul_b = MUL_W'(dyw_q);
      end
      S_MUL1: begin
        mul_a = MUL_W'(k_q[1] ? wxb_q : wxa_q);
        mul_b = MUL_W'(k_q[0] ? wyb_q : wya_q);
      end
      S_MUL2: begin
        mul_a = MUL_W'(mul_p);
        mul_b = (mul_p == '0) ? '0 : MUL_W'(grid_rd_q);
      end
      default: ;
    endcase
  end

  cblt_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  assign acc_abs   = acc_q[ACC_W-1] ? ACC_W'(-acc_q) : ACC_W'(acc_q);
  assign div_start = (state_q == S_DIVS);

  cblt_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   ({acc_abs[ACC_W-2:0], 1'b0} + ACC_W'(den_q)),
    .den_i   ({den_q, 1'b0}),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  assign out_load = (state_q == S_FIN) && (!out_valid_q || out_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (acc) begin
            state_q <= (in_i.command == CMD_QUERY) ? S_SRCH : S_FIN;
          end
        end
        S_SRCH: begin
          if (x_res.done && y_res.done) begin
            state_q <= S_DEN;
          end
        end
        S_DEN:  state_q <= S_DENW;
        S_DENW: state_q <= S_MUL1;
        S_MUL1: state_q <= S_MUL2;
        S_MUL2: state_q <= S_ACC;
        S_ACC:  state_q <= (k_q == 2'd3) ? S_DIVS : S_MUL1;
        S_DIVS: state_q <= S_DIV;
        S_DIV: begin
          if (div_done) begin
            state_q <= S_FIN;
          end
        end
        S_FIN: begin
          if (out_load) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        qx_q    <= in_i.query_x;
        qy_q    <= in_i.query_y;
        res_q   <= '0;
        flags_q <= '0;
      end
      S_SRCH: begin
        flags_q <= {!y_res.bracket, !x_res.bracket};
        xi_q    <= XW'(x_res.lo);
        yi_q    <= YW'(y_res.lo);
        wxa_q   <= x_res.bracket ? W_W'(x2mq) : W_W'(1);
        wxb_q   <= x_res.bracket ? W_W'(qmx1) : '0;
        dxw_q   <= x_res.bracket ? W_W'(x2mx1) : W_W'(1);
        wya_q   <= y_res.bracket ? W_W'(y2mq) : W_W'(1);
        wyb_q   <= y_res.bracket ? W_W'(qmy1) : '0;
        dyw_q   <= y_res.bracket ? W_W'(y2my1) : W_W'(1);
      end
      S_DENW: begin
        den_q <= DEN_W'(mul_p);
        acc_q <= '0;
        k_q   <= '0;
      end
      S_ACC: begin
        acc_q <= acc_q + mul_p;
        k_q   <= k_q + 1'b1;
      end
      S_DIVS: begin
        neg_q <= acc_q[ACC_W-1];
      end
      S_DIV: begin
        if (div_done) begin
          res_q <= VAL_W'(neg_q ? (~div_quo + 1'b1) : div_quo);
        end
      end
      default: ;
    endcase
    if (out_load) begin
      out_value_q <= res_q;
      out_flags_q <= flags_q;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.result_value = out_value_q;
  assign out_o.clamp_flags  = out_flags_q;

  a_search_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DEN) |-> (x_res.done && y_res.done))
    else $error("weights formed before both axis searches finished");

  a_corner_den : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIVS && flags_q == 2'b11) |-> (den_q == DEN_W'(1)))
    else $error("cell area not one for a corner lookup");

  a_out_load : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> (out_valid_q && state_q == S_IDLE))
    else $error("finished item not moved into output register");

endmodule

>>> verif/cblt_checker.sv
`timescale 1ns / 100ps
module cblt_checker import cblt_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  cblt_in_if                   in_m,
  cblt_out_if                  out_m,
  output int                   fail_cnt_o,
  output int                   pending_o,
  output int                   query_cnt_o,
  output int                   clamp_cnt_o
);

  localparam int NX = DEF_MAX_X_POINTS;
  localparam int NY = DEF_MAX_Y_POINTS;
  localparam logic [1:0] FLAG_X = 2'b01;
  localparam logic [1:0] FLAG_Y = 2'b10;

  typedef struct packed {
    logic signed [VAL_W-1:0] value;
    logic [1:0]              flags;
  } lookup_t;

  logic signed [VAL_W-1:0] x_axis [NX];
  logic signed [VAL_W-1:0] y_axis [NY];
  logic signed [VAL_W-1:0] grid [NX*NY];
  logic [CFG_W-1:0]        x_cnt, y_cnt;
  lookup_t                 lookup_q [$];

  function automatic int eff_count(logic [CFG_W-1:0] n, int maxn);
    if (n == 0) return 1;
    return (n > maxn) ? maxn : int'(n);
  endfunction

  function automatic bit axis_bracket(input bit is_x, input int n, input longint t,
                                      output int lo);
    longint p;
    p = is_x ? x_axis[0] : y_axis[0];
    lo = 0;
    if (t <= p) return 0;
    for (int i = 1; i < n; i++) begin
      p = is_x ? x_axis[i] : y_axis[i];
      if (t < p) begin
        lo = i - 1;
        return 1;
      end
    end
    lo = n - 1;
    return 0;
  endfunction

  function automatic longint div_round(longint num, longint den);
    longint a, q;
    a = (num < 0) ? -num : num;
    q = (2 * a + den) / (2 * den);
    return (num < 0) ? -q : q;
  endfunction

  function automatic longint g(int r, int c);
    return grid[r*NY + c];
  endfunction

  function automatic lookup_t bilinear(longint qx, longint qy);
    lookup_t res;
    int      xi, yi;
    bit      bx, by;
    longint  x1, x2, y1, y2, num, v;
    bx = axis_bracket(1, eff_count(x_cnt, NX), qx, xi);
    by = axis_bracket(0, eff_count(y_cnt, NY), qy, yi);
    res.flags = (bx ? 2'b00 : FLAG_X) | (by ? 2'b00 : FLAG_Y);
    if (bx) begin
      x1 = x_axis[xi];
      x2 = x_axis[xi+1];
    end
    if (by) begin
      y1 = y_axis[yi];
      y2 = y_axis[yi+1];
    end
    if (bx && by) begin
      num = (x2-qx)*(y2-qy)*g(xi, yi) + (x2-qx)*(qy-y1)*g(xi, yi+1)
          + (qx-x1)*(y2-qy)*g(xi+1, yi) + (qx-x1)*(qy-y1)*g(xi+1, yi+1);
      v = div_round(num, (x2-x1)*(y2-y1));
    end else if (bx) begin
      v = div_round((x2-qx)*g(xi, yi) + (qx-x1)*g(xi+1, yi), x2-x1);
    end else if (by) begin
      v = div_round((y2-qy)*g(xi, yi) + (qy-y1)*g(xi, yi+1), y2-y1);
    end else begin
      v = g(xi, yi);
    end
    res.value = v[VAL_W-1:0];
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    lookup_t expd;
    if (!rst_ni) begin
      x_cnt = 1;
      y_cnt = 1;
      lookup_q.delete();
      fail_cnt_o = 0;
      query_cnt_o = 0;
      clamp_cnt_o = 0;
      foreach (x_axis[i]) x_axis[i] = '0;
      foreach (y_axis[i]) y_axis[i] = '0;
      foreach (grid[i]) grid[i] = '0;
    end else begin
      if (out_m.valid && out_m.ready) begin
        if (lookup_q.size() == 0) begin
          fail_cnt_o++;
          if (fail_cnt_o <= 10)
            $display("ERROR: unexpected result value=%0d flags=%0d",
                     out_m.result_value, out_m.clamp_flags);
        end else begin
          expd = lookup_q.pop_front();
          if (out_m.result_value !== expd.value || out_m.clamp_flags !== expd.flags) begin
            fail_cnt_o++;
            if (fail_cnt_o <= 10)
              $display("ERROR: expected value=%0d flags=%0d, got value=%0d flags=%0d",
                       expd.value, expd.flags, out_m.result_value, out_m.clamp_flags);
          end
        end
      end
      if (in_m.valid && in_m.ready) begin
        expd = '0;
        case (in_m.command)
          CMD_WR_X: x_axis[in_m.row_index] = in_m.write_value;
          CMD_WR_Y: y_axis[in_m.col_index] = in_m.write_value;
          CMD_WR_G: grid[in_m.row_index*NY + in_m.col_index] = in_m.write_value;
          default: begin
            expd = bilinear(in_m.query_x, in_m.query_y);
            query_cnt_o++;
            if (expd.flags != 2'b00) clamp_cnt_o++;
          end
        endcase
        lookup_q.push_back(expd);
      end
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_X_POINTS) x_cnt = cfg_data_i;
        else if (cfg_idx_i == CFG_Y_POINTS) y_cnt = cfg_data_i;
      end
    end
    pending_o = lookup_q.size();
  end

endmodule

>>> verif/tb_top.sv
`timescale 1ns / 100ps
module tb_top;
  import cblt_pkg::*;

  localparam int NX = DEF_MAX_X_POINTS;
  localparam int NY = DEF_MAX_Y_POINTS;
  localparam int CYCLE_LIMIT = 600000;

  logic                 clk_i, rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0]     cfg_data_i;
  int                   fail_cnt, pending, query_cnt, clamp_cnt;
  int                   gap_pct, stall_pct, hold_cycles, cycle_cnt;
  logic signed [VAL_W-1:0] xs [NX];
  logic signed [VAL_W-1:0] ys [NY];
  int                   nx_use, ny_use;

  cblt_in_if  in_if ();
  cblt_out_if out_if ();

  clamped_bilinear_table_lookup_top dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_i(in_if.sink), .out_o(out_if.source)
  );

  cblt_checker u_checker (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_m(in_if), .out_m(out_if),
    .fail_cnt_o(fail_cnt), .pending_o(pending),
    .query_cnt_o(query_cnt), .clamp_cnt_o(clamp_cnt)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    cycle_cnt = 0;
    forever begin
      @(posedge clk_i);
      cycle_cnt++;
      if (cycle_cnt > CYCLE_LIMIT) begin
        $display("timeout after %0d cycles", cycle_cnt);
        $display("FAIL");
        $finish;
      end
    end
  end

  // receiver: random stall plus long hold-off on request
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_cycles > 0) begin
        out_if.ready = 1'b0;
        hold_cycles--;
      end else begin
        out_if.ready = ($urandom_range(99) >= stall_pct);
      end
    end
  end

  task automatic send_item(logic [CMD_W-1:0] cmd, logic [IDX_W-1:0] r, logic [IDX_W-1:0] c,
                           logic signed [VAL_W-1:0] wv, logic signed [VAL_W-1:0] qx,
                           logic signed [VAL_W-1:0] qy);
    @(negedge clk_i);
    while ($urandom_range(99) < gap_pct) begin
      in_if.valid = 1'b0;
      @(negedge clk_i);
    end
    in_if.valid = 1'b1;
    in_if.command = cmd;
    in_if.row_index = r;
    in_if.col_index = c;
    in_if.write_value = wv;
    in_if.query_x = qx;
    in_if.query_y = qy;
    do @(posedge clk_i); while (!in_if.ready);
    if (cmd == CMD_WR_X) xs[r] = wv;
    if (cmd == CMD_WR_Y) ys[c] = wv;
  endtask

  task automatic query(logic signed [VAL_W-1:0] qx, logic signed [VAL_W-1:0] qy);
    send_item(CMD_QUERY, IDX_W'($urandom), IDX_W'($urandom), VAL_W'($urandom), qx, qy);
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_if.valid = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic set_counts(logic [CFG_W-1:0] nx, logic [CFG_W-1:0] ny);
    drain();
    cfg_we_i = 1'b1;
    cfg_idx_i = CFG_X_POINTS;
    cfg_data_i = nx;
    @(negedge clk_i);
    cfg_idx_i = CFG_Y_POINTS;
    cfg_data_i = ny;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    nx_use = (nx == 0) ? 1 : (nx > NX ? NX : nx);
    ny_use = (ny == 0) ? 1 : (ny > NY ? NY : ny);
  endtask

  function automatic logic signed [VAL_W-1:0] pick_coord(bit is_x);
    int n, i, sel;
    longint a, b;
    n = is_x ? nx_use : ny_use;
    i = $urandom_range(n - 1);
    a = is_x ? xs[i] : ys[i];
    sel = $urandom_range(9);
    if (sel < 2 || n < 2) return VAL_W'($urandom);
    if (sel < 4) return VAL_W'(a);
    i = $urandom_range(n - 2);
    a = is_x ? xs[i] : ys[i];
    b = is_x ? xs[i+1] : ys[i+1];
    if (b <= a) return VAL_W'(a);
    return VAL_W'(a + longint'($urandom_range(int'(b - a))));
  endfunction

  task automatic random_items(int n);
    int k;
    for (int j = 0; j < n; j++) begin
      k = $urandom_range(99);
      if (k < 70)
        query(pick_coord(1), pick_coord(0));
      else if (k < 94)
        send_item(CMD_WR_G, IDX_W'($urandom), IDX_W'($urandom), VAL_W'($urandom),
                  VAL_W'($urandom), VAL_W'($urandom));
      else if (k < 97)
        send_item(CMD_WR_X, IDX_W'($urandom), IDX_W'($urandom), VAL_W'($urandom),
                  VAL_W'($urandom), VAL_W'($urandom));
      else
        send_item(CMD_WR_Y, IDX_W'($urandom), IDX_W'($urandom), VAL_W'($urandom),
                  VAL_W'($urandom), VAL_W'($urandom));
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CFG_X_POINTS;
    cfg_data_i = '0;
    in_if.valid = 1'b0;
    in_if.command = CMD_QUERY;
    in_if.row_index = '0;
    in_if.col_index = '0;
    in_if.write_value = '0;
    in_if.query_x = '0;
    in_if.query_y = '0;
    gap_pct = 0;
    stall_pct = 0;
    hold_cycles = 0;
    nx_use = 1;
    ny_use = 1;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // load the whole map: axes end to end, every grid entry
    for (int i = 0; i < NX; i++)
      send_item(CMD_WR_X, IDX_W'(i), '0, VAL_W'(-32768 + i * 4369), '0, '0);
    for (int i = 0; i < NY; i++)
      send_item(CMD_WR_Y, '0, IDX_W'(i),
                VAL_W'(-30000 + i * 4000 + int'($urandom_range(1500))), '0, '0);
    for (int i = 0; i < NX * NY; i++)
      send_item(CMD_WR_G, IDX_W'(i / NY), IDX_W'(i % NY), VAL_W'($urandom), '0, '0);

    set_counts(5'd16, 5'd16);
    send_item(CMD_WR_G, 4'd0, 4'd0, 16'sh8000, '0, '0);
    send_item(CMD_WR_G, 4'd15, 4'd15, 16'sh7fff, '0, '0);
    query(16'sh8000, 16'sh8000);
    query(16'sh7fff, 16'sh7fff);
    query(xs[0], ys[5]);
    query(xs[15], ys[3] + 16'sd7);
    query(xs[4], ys[15] + 16'sd100);
    query(xs[7], ys[9]);
    query(xs[7] + 16'sd1, ys[9] + 16'sd1);
    query(xs[14] + 16'sd4368, ys[14] + 16'sd1);
    query(16'sh0000, 16'sh0000);
    query(16'shffff, 16'sh5555);
    query(16'sh2aaa, 16'shffff);
    send_item(CMD_WR_X, 4'd3, 4'd0, xs[2] - 16'sd10, '0, '0);
    query(xs[2] + 16'sd5, ys[6]);
    query(xs[3] - 16'sd3, ys[6] - 16'sd3);
    set_counts(5'd0, 5'd31);
    query(16'sh7fff, ys[8] + 16'sd1);
    set_counts(5'd1, 5'd1);
    query(16'sd0, 16'sd0);
    set_counts(5'd17, 5'd0);
    query(xs[8] + 16'sd5, 16'sd0);
    set_counts(5'd2, 5'd2);
    query(xs[0] + 16'sd2000, ys[0] + 16'sd1000);

    set_counts(5'd16, 5'd16);
    gap_pct = 0;  stall_pct = 0;  random_items(30);
    set_counts(5'($urandom_range(2, 16)), 5'($urandom_range(2, 16)));
    gap_pct = 82; stall_pct = 0;  random_items(25);
    set_counts(5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)));
    gap_pct = 0;  stall_pct = 82; random_items(25);
    set_counts(5'd16, 5'd2);
    gap_pct = 24; stall_pct = 24; random_items(25);

    // hold off the receiver while items keep coming
    set_counts(5'd3, 5'd16);
    gap_pct = 0;  stall_pct = 0;
    hold_cycles = 400;
    random_items(20);

    drain();
    $display("covered %0d queries (%0d clamped on an axis) with point counts from 0 to 31",
             query_cnt, clamp_cnt);
    if (fail_cnt == 0) begin
      $display("PASS");
    end else begin
      $display("%0d mismatches", fail_cnt);
      $display("FAIL");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/core/cblt_pkg.sv
rtl/core/cblt_if.sv
rtl/core/cblt_search.sv
rtl/core/cblt_mul.sv
rtl/core/cblt_div.sv
rtl/core/clamped_bilinear_table_lookup_top.sv
verif/cblt_checker.sv
verif/tb_top.sv
